>>> src/nas_pkg.sv
// Shared types and constants for the node acquisition sequencer.
`default_nettype none
package nas_pkg;

  localparam int PERIOD_W   = 16;
  localparam int ID_FIELD_W = 8;
  localparam int NEW_ID_W   = 9;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam int MAX_MSGS   = 3;
  localparam int SLOT_IDX_W = 2;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_POLL   = 2'd1,
    MODE_SET    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_START_DATA = 3'd0,
    KIND_START_ACQ  = 3'd1,
    KIND_POLL       = 3'd2,
    KIND_SET_ID     = 3'd3,
    KIND_STOP_ACQ   = 3'd4
  } kind_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_KEEPALIVE_PERIOD = 3'd0,
    CFG_POLL_PERIOD      = 3'd1,
    CFG_POLL_DURATION    = 3'd2,
    CFG_ASSIGN_PERIOD    = 3'd3,
    CFG_OWN_ID           = 3'd4,
    CFG_UNASSIGNED_ID    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_EMIT = 2'd2
  } seq_state_t;

  typedef struct packed {
    logic                  report;
    logic                  acq;
    logic                  clr;
    logic [ID_FIELD_W-1:0] rid;
  } event_t;

  typedef struct packed {
    logic [PERIOD_W-1:0]   keepalive_period;
    logic [PERIOD_W-1:0]   poll_period;
    logic [PERIOD_W-1:0]   poll_duration;
    logic [PERIOD_W-1:0]   assign_period;
    logic [ID_FIELD_W-1:0] own_id;
    logic [ID_FIELD_W-1:0] unassigned_id;
  } cfg_t;

  typedef struct packed {
    kind_t                 kind;
    logic [ID_FIELD_W-1:0] sender;
    logic                  clr;
    logic [NEW_ID_W-1:0]   new_id;
  } msg_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage
`default_nettype wire

>>> src/nas_front.sv
// Input side: takes event beats, decodes them and queues them for the sequencer.
`default_nettype none
module nas_front
  import nas_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic [0:0]           in_tuser,
  output logic                      q_valid,
  output event_t                    q_evt,
  input  wire logic                 q_pop
);

  event_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  event_t     evt;
  logic       push;
  logic       pop;

  // tdata: acq_req, clear_request, reporter_id from bit 0 up
  always_comb begin
    evt.report = in_tuser[0];
    evt.acq    = in_tdata[0];
    evt.clr    = in_tdata[1];
    evt.rid    = in_tdata[2 +: ID_FIELD_W];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_evt     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/nas_rem.sv
// Serial remainder unit: one dividend bit per cycle, restoring form.
`default_nettype none
module nas_rem
  import nas_pkg::*;
#(
  parameter int DIVIDEND_W = 16,
  parameter int DIVISOR_W  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output rem_status_t                status
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] dvd_r, dvd_nxt;
  logic [DIVISOR_W-1:0]  div_r, div_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    trial;

  assign trial = {rem_r, dvd_r[DIVIDEND_W-1]};

  always_comb begin
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
      step_nxt = STEP_W'(DIVIDEND_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // trial stays below twice the divisor, so one subtract restores it
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = DIVISOR_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = DIVISOR_W'(trial);
      end
      dvd_nxt  = {dvd_r[DIVIDEND_W-2:0], 1'b0};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign status.done = done_r;
  assign status.zero = (rem_r == '0);

endmodule
`default_nettype wire

>>> src/nas_back.sv
// Sequencer: mode, tick counter and highest ID; builds and sends message beats.
`default_nettype none
module nas_back
  import nas_pkg::*;
#(
  parameter int COUNT_BITS = 16,
  parameter int ID_BITS    = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfg_t                  cfg,
  input  wire logic                  q_valid,
  input  wire event_t                q_evt,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [2:0]                 out_tuser,
  output logic                       out_tlast
);

  localparam int CMP_W = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;

  seq_state_t            state_r, state_nxt;
  mode_t                 mode_r, mode_nxt;
  logic [COUNT_BITS-1:0] tick_r, tick_nxt;
  logic [ID_BITS-1:0]    high_r, high_nxt;
  msg_t                  slot_r [MAX_MSGS];
  msg_t                  slot_nxt [MAX_MSGS];
  logic [SLOT_IDX_W-1:0] cnt_r, cnt_nxt;
  logic [SLOT_IDX_W-1:0] idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  msg_t                  out_msg_r, out_msg_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [COUNT_BITS-1:0] tc1;
  logic [CMP_W-1:0]      tc1_x;
  logic [ID_BITS-1:0]    rid;
  logic [ID_BITS:0]      high_inc;
  logic                  rem_start;
  logic                  emit_fire;
  logic                  emit_last;
  rem_status_t           rem_st;
  msg_t                  m_sd, m_sa, m_poll, m_set, m_stop;

  nas_rem #(
    .DIVIDEND_W (COUNT_BITS),
    .DIVISOR_W  (PERIOD_W)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (tc1),
    .divisor  (cfg.poll_period),
    .status   (rem_st)
  );

  assign tc1      = tick_r + COUNT_BITS'(1);
  assign tc1_x    = CMP_W'(tc1);
  assign rid      = ID_BITS'(q_evt.rid);
  assign high_inc = {1'b0, high_r} + (ID_BITS + 1)'(1);

  always_comb begin
    m_sd   = '{kind: KIND_START_DATA, sender: cfg.own_id, clr: 1'b0, new_id: '0};
    m_sa   = '{kind: KIND_START_ACQ, sender: cfg.own_id, clr: q_evt.clr, new_id: '0};
    m_poll = '{kind: KIND_POLL, sender: cfg.own_id, clr: 1'b0, new_id: '0};
    m_set  = '{kind: KIND_SET_ID, sender: cfg.unassigned_id, clr: 1'b0,
               new_id: NEW_ID_W'(high_inc)};
    m_stop = '{kind: KIND_STOP_ACQ, sender: cfg.own_id, clr: 1'b0, new_id: '0};
  end

  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign emit_last = (idx_r == cnt_r - SLOT_IDX_W'(1));

  // event decode and datapath
  always_comb begin
    q_pop         = 1'b0;
    rem_start     = 1'b0;
    mode_nxt      = mode_r;
    tick_nxt      = tick_r;
    high_nxt      = high_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_msg_nxt   = out_msg_r;
    out_last_nxt  = out_last_r;
    for (int i = 0; i < MAX_MSGS; i++) begin
      slot_nxt[i] = slot_r[i];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cnt_nxt = '0;
          idx_nxt = '0;
          if (q_evt.report) begin
            if (rid > high_r) begin
              high_nxt = rid;
            end
          end else begin
            unique case (mode_r)
              MODE_NORMAL: begin
                logic ka;
                ka = (tc1_x == CMP_W'(cfg.keepalive_period));
                tick_nxt = (ka || q_evt.acq) ? '0 : tc1;
                slot_nxt[0] = ka ? m_sd : m_sa;
                slot_nxt[1] = m_sa;
                slot_nxt[2] = m_sa;
                cnt_nxt = {q_evt.acq, ka};
                if (q_evt.acq) begin
                  mode_nxt = MODE_POLL;
                  if (q_evt.clr) begin
                    high_nxt = '0;
                  end
                end
              end
              MODE_POLL: begin
                // remainder test runs on the captured count after the update
                rem_start = (cfg.poll_period != '0);
                if (tc1_x >= CMP_W'(cfg.poll_duration)) begin
                  mode_nxt = MODE_SET;
                  tick_nxt = '0;
                end else begin
                  tick_nxt = tc1;
                end
              end
              MODE_SET: begin
                if (!q_evt.acq) begin
                  mode_nxt    = MODE_NORMAL;
                  tick_nxt    = '0;
                  slot_nxt[0] = m_stop;
                  slot_nxt[1] = m_stop;
                  cnt_nxt     = SLOT_IDX_W'(2);
                end else if (tc1_x == CMP_W'(cfg.assign_period)) begin
                  tick_nxt    = '0;
                  slot_nxt[0] = m_set;
                  cnt_nxt     = SLOT_IDX_W'(1);
                end else begin
                  tick_nxt = tc1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_DIV: begin
        if (rem_st.done && rem_st.zero) begin
          slot_nxt[0] = m_poll;
          cnt_nxt     = SLOT_IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_valid_nxt = 1'b1;
          out_msg_nxt   = slot_r[idx_r];
          out_last_nxt  = emit_last;
          idx_nxt       = emit_last ? '0 : idx_r + SLOT_IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (rem_start) begin
          state_nxt = ST_DIV;
        end else if (q_pop && cnt_nxt != '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (rem_st.done) begin
          state_nxt = rem_st.zero ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_fire && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_MSGS; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
    out_msg_r  <= out_msg_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_NORMAL;
      tick_r      <= '0;
      high_r      <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      tick_r      <= tick_nxt;
      high_r      <= high_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_msg_r.new_id, out_msg_r.clr, out_msg_r.sender};
  assign out_tuser  = out_msg_r.kind;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

>>> src/node_acquisition_sequencer_core.sv
// Top level of the node acquisition sequencer: configuration registers and channels.
// Each input beat is a tick or a node report; a tick yields zero to three message
// beats, the last one marked by out_tlast. In poll mode with a nonzero poll
// period a tick also runs the serial remainder unit, which tests the count against
// the poll period one bit per cycle. A two-entry queue in front of the sequencer
// keeps taking beats while it works, as long as it has room, and the output
// register holds a finished beat while the next event runs.
`default_nettype none
module node_acquisition_sequencer_core
  import nas_pkg::*;
#(
  parameter int COUNT_BITS = 16,
  parameter int ID_BITS    = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,  // acq_req, clear_request, reporter_id
  input  wire logic [0:0]            in_tuser,  // cmd
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata, // sender_id, clear_flag, new_id
  output logic [2:0]                 out_tuser, // msg_kind
  output logic                       out_tlast  // last
);

  cfg_t   cfg_r, cfg_nxt;
  logic   q_valid;
  event_t q_evt;
  logic   q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_KEEPALIVE_PERIOD: cfg_nxt.keepalive_period = cfg_wdata;
        CFG_POLL_PERIOD:      cfg_nxt.poll_period      = cfg_wdata;
        CFG_POLL_DURATION:    cfg_nxt.poll_duration    = cfg_wdata;
        CFG_ASSIGN_PERIOD:    cfg_nxt.assign_period    = cfg_wdata;
        CFG_OWN_ID:           cfg_nxt.own_id           = cfg_wdata[ID_FIELD_W-1:0];
        CFG_UNASSIGNED_ID:    cfg_nxt.unassigned_id    = cfg_wdata[ID_FIELD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.keepalive_period <= PERIOD_W'(1000);
      cfg_r.poll_period      <= PERIOD_W'(100);
      cfg_r.poll_duration    <= PERIOD_W'(1000);
      cfg_r.assign_period    <= PERIOD_W'(100);
      cfg_r.own_id           <= '0;
      cfg_r.unassigned_id    <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  nas_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_evt     (q_evt),
    .q_pop     (q_pop)
  );

  nas_back #(
    .COUNT_BITS (COUNT_BITS),
    .ID_BITS    (ID_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_evt      (q_evt),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
